### hdl/pkc_pkg.sv
// shared constants, types and status codes of the pointer-keyed hash cache
package pkc_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int WORD_W      = 64;
    localparam int HASH_W      = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [1:0]        status_t;

    localparam addr_t SLOT_MASK = ADDR_W'(TABLE_DEPTH - 1);

    // murmur3 64-bit finalizer constants
    localparam word_t FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam word_t FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int    FMIX_SHIFT = 33;

    // result status codes
    localparam status_t ST_HIT      = 2'd0;
    localparam status_t ST_INSERTED = 2'd1;
    localparam status_t ST_REFUSED  = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

endpackage

### hdl/pointer_keyed_hash_cache.sv
// top level of the pointer-keyed hash cache: probe sequencer, tables and result register
//
// Usage:
//   s_ channel carries one lookup per beat: key and fill value in s_tdata,
//   the realized flag in s_tuser. m_ channel returns one beat per lookup:
//   the value in m_tdata and the status (hit, inserted, refused, full) in m_tuser.
//   After reset the block sweeps both tables to zero, one slot a cycle,
//   over all TABLE_DEPTH (8192) slots; s_tready stays low during the sweep.
//   A lookup is then hashed on the shared 32x32 multiplier (two 64-bit
//   multiplies, four passes each), its first slot is read from the tables
//   and the probe walk follows; a new lookup is taken only once the result
//   is loaded, so the block holds one lookup at a time. The time a lookup
//   takes grows with the slots the probe walk over the table memory visits.
//   Results wait in an output register; while the receiver stalls, a
//   finished lookup holds in the response state and no new beat is taken.
//   Entries are never removed; a full table returns the fill value unstored.
module pointer_keyed_hash_cache (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [127:0]     s_tdata,   // key [63:0], fill_value [127:64]
    input  logic             s_tuser,   // realized [0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output pkc_pkg::word_t   m_tdata,   // value [63:0]
    output pkc_pkg::status_t m_tuser    // status [1:0]
);
    import pkc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg, state_next;
    addr_t      clr_addr_reg, clr_addr_next;
    addr_t      slot_reg, slot_next;
    cnt_t       cnt_reg, cnt_next;
    word_t      key_reg, key_next;
    word_t      fill_reg, fill_next;
    logic       realized_reg, realized_next;
    word_t      res_value_reg, res_value_next;
    status_t    res_status_reg, res_status_next;
    logic       m_tvalid_reg, m_tvalid_next;
    word_t      m_tdata_reg, m_tdata_next;
    status_t    m_tuser_reg, m_tuser_next;

    logic       s_accept;
    logic       hash_start;
    logic       hash_done;
    hash_t      hash_val;
    addr_t      slot_adv;
    addr_t      rd_addr;
    logic       wr_en;
    addr_t      wr_addr;
    word_t      wr_key;
    word_t      wr_value;
    word_t      held_key;
    word_t      held_value;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign hash_start = s_accept;
    assign slot_adv   = (slot_reg + ADDR_W'(1)) & SLOT_MASK;
    assign rd_addr    = (state_reg == S_PROBE) ? slot_adv : slot_reg;

    // hash unit
    pkc_fmix u_fmix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_tdata[63:0]),
        .done    (hash_done),
        .hash    (hash_val)
    );

    // key and value tables
    pkc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_addr (rd_addr),
        .rd_data (held_key)
    );

    pkc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_value),
        .rd_addr (rd_addr),
        .rd_data (held_value)
    );

    // clearing sweep, probe walk and result hand-off
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        fill_next       = fill_reg;
        realized_next   = realized_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_key          = key_reg;
        wr_value        = fill_reg;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_key        = '0;
                wr_value      = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    key_next      = s_tdata[63:0];
                    fill_next     = s_tdata[127:64];
                    realized_next = s_tuser;
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    slot_next  = hash_val[ADDR_W-1:0] & SLOT_MASK;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_PROBE;
            end
            S_PROBE: begin
                priority if (held_key == key_reg) begin
                    res_value_next  = held_value;
                    res_status_next = ST_HIT;
                    state_next      = S_RESP;
                end else if (held_key == '0) begin
                    if (!realized_reg || (fill_reg == '0)) begin
                        res_value_next  = '0;
                        res_status_next = ST_REFUSED;
                    end else begin
                        wr_en           = 1'b1;
                        res_value_next  = fill_reg;
                        res_status_next = ST_INSERTED;
                    end
                    state_next = S_RESP;
                end else if (cnt_reg == CNT_W'(TABLE_DEPTH - 1)) begin
                    res_value_next  = fill_reg;
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end else begin
                    slot_next = slot_adv;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        key_reg        <= key_next;
        fill_reg       <= fill_next;
        realized_reg   <= realized_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### hdl/pkc_ram.sv
// generic simple dual-port ram with registered read
module pkc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/pkc_fmix.sv
// iterative fmix64 hash built around one shared 32x32 multiplier
module pkc_fmix (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  pkc_pkg::word_t key,
    output logic          done,
    output pkc_pkg::hash_t hash
);
    import pkc_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    logic        done_reg, done_next;
    word_t       x_reg, x_next;
    word_t       acc_reg, acc_next;
    word_t       prod_reg, prod_next;

    logic [1:0]  sub;
    word_t       coef;
    logic [31:0] mul_a, mul_b;
    logic [31:0] sum_hi;
    word_t       full;

    // operand selection for the shared multiplier
    assign sub   = step_reg[1:0];
    assign coef  = step_reg[2] ? FMIX_C2 : FMIX_C1;
    assign mul_a = (sub == 2'd1) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (sub == 2'd2) ? coef[63:32] : coef[31:0];

    // low 64 bits of the product: lo*lo + ((hi*lo + lo*hi) << 32)
    assign prod_next = word_t'(mul_a) * word_t'(mul_b);
    assign sum_hi    = acc_reg[63:32] + prod_reg[31:0];
    assign full      = {sum_hi, acc_reg[31:0]};

    // step sequencer
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            x_next    = key ^ (key >> FMIX_SHIFT);
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            unique case (sub)
                2'd0: begin
                    acc_next = acc_reg;
                end
                2'd1: begin
                    acc_next = prod_reg;
                end
                2'd2: begin
                    acc_next = full;
                end
                2'd3: begin
                    x_next = full ^ (full >> FMIX_SHIFT);
                    if (step_reg == 3'd7) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign hash = x_reg[31:0];

endmodule

### hdl/pkc_checker.sv
// port-level assertions for the pointer-keyed hash cache and their binding
module pkc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input pkc_pkg::word_t   m_tdata,
    input pkc_pkg::status_t m_tuser
);
    import pkc_pkg::*;

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // one lookup at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a lookup is in progress");

    // a result never appears in the cycle after a lookup starts
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared before hashing finished");

    // a refused miss always returns null
    a_refused_is_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_REFUSED)) |-> (m_tdata == '0))
        else $error("refused miss returned a nonzero value");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind pointer_keyed_hash_cache pkc_checker u_pkc_checker (.*);

### tb/sv/pointer_keyed_hash_cache_tb.sv
// self-checking testbench for the pointer-keyed hash cache: directed table, random and closing phases
`timescale 1ns / 1ps

module pointer_keyed_hash_cache_tb;
    import pkc_pkg::*;

    // one lookup outcome: returned value and status code
    typedef struct packed {
        word_t   value;
        status_t status;
    } lookup_t;

    // directed stimulus row; the typed outcome is used only where typed is set
    typedef struct packed {
        word_t   key;
        logic    realized;
        word_t   fill;
        logic    typed;
        word_t   want_value;
        status_t want_status;
    } probe_row_t;

    localparam word_t ALL_ONES = '1;
    localparam word_t TOP_BIT  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t ALT_5    = {(WORD_W/2){2'b01}};
    localparam word_t ALT_A    = {(WORD_W/2){2'b10}};
    localparam word_t HI_HALF  = {{(WORD_W/2){1'b1}}, {(WORD_W/2){1'b0}}};
    localparam word_t LO_HALF  = {{(WORD_W/2){1'b0}}, {(WORD_W/2){1'b1}}};

    localparam int N_DIRECTED   = 18;
    localparam int RANDOM_ITEMS = 1380;
    localparam int HOLD_AT      = 300;    // result beat after which the sink holds off
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 40000;  // covers reset sweep and full-table probes
    localparam int PRINT_LIMIT  = 200;

    // starting from an empty table
    localparam probe_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{64'd0,    1'b0 | 1'b1, 64'd5,    1'b1, 64'd0,    ST_HIT},       // zero key, empty slot
        '{ALL_ONES, 1'b0,        ALL_ONES, 1'b1, 64'd0,    ST_REFUSED},   // not realized
        '{ALL_ONES, 1'b1,        64'd0,    1'b1, 64'd0,    ST_REFUSED},   // no fill value
        '{ALL_ONES, 1'b1,        ALL_ONES, 1'b1, ALL_ONES, ST_INSERTED},
        '{ALL_ONES, 1'b0,        64'd1,    1'b1, ALL_ONES, ST_HIT},
        '{64'd1,    1'b1,        64'd1,    1'b1, 64'd1,    ST_INSERTED},
        '{64'd1,    1'b1,        TOP_BIT,  1'b1, 64'd1,    ST_HIT},
        '{TOP_BIT,  1'b1,        ALT_5,    1'b1, ALT_5,    ST_INSERTED},
        '{ALT_5,    1'b1,        ALT_A,    1'b1, ALT_A,    ST_INSERTED},
        '{ALT_A,    1'b0,        ALT_A,    1'b1, 64'd0,    ST_REFUSED},
        '{ALT_A,    1'b1,        ALT_A,    1'b1, ALT_A,    ST_INSERTED},
        '{64'd0,    1'b1,        ALL_ONES, 1'b1, 64'd0,    ST_HIT},       // zero key again
        '{ALT_5,    1'b0,        64'd0,    1'b1, ALT_A,    ST_HIT},
        '{HI_HALF,  1'b1,        LO_HALF,  1'b0, 64'd0,    ST_HIT},
        '{LO_HALF,  1'b1,        HI_HALF,  1'b0, 64'd0,    ST_HIT},
        '{64'h0000_0001_0000_0000, 1'b1, 64'd1, 1'b0, 64'd0, ST_HIT},
        '{HI_HALF,  1'b0,        64'd0,    1'b0, 64'd0,    ST_HIT},
        '{64'h0123_4567_89ab_cdef, 1'b0, ALL_ONES, 1'b0, 64'd0, ST_HIT}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // key [63:0], fill_value [127:64]
    logic         s_tuser;    // realized [0]
    logic         m_tvalid;
    logic         m_tready;
    word_t        m_tdata;    // value [63:0]
    status_t      m_tuser;    // status [1:0]

    // shadow of the cache tables, empty after reset
    bit [WORD_W-1:0] shadow_keys [TABLE_DEPTH];
    bit [WORD_W-1:0] shadow_vals [TABLE_DEPTH];

    lookup_t pending_results [$];
    word_t   known_keys [$];
    int      mismatches;
    int      rx_beats;
    int      send_calm;
    bit      fast_mode;

    pointer_keyed_hash_cache i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // low 32 bits of the 64-bit murmur3 finalizer
    function automatic hash_t fmix_low(word_t k);
        word_t x;
        x = k;
        x = x ^ (x >> FMIX_SHIFT);
        x = x * FMIX_C1;
        x = x ^ (x >> FMIX_SHIFT);
        x = x * FMIX_C2;
        x = x ^ (x >> FMIX_SHIFT);
        return x[HASH_W-1:0];
    endfunction

    // linear probe over the shadow tables, inserting on an allowed miss
    function automatic lookup_t cache_lookup(word_t key, logic realized, word_t fill);
        lookup_t r;
        addr_t   slot;
        slot = addr_t'(fmix_low(key)) & SLOT_MASK;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (shadow_keys[slot] == key) begin
                r.value  = shadow_vals[slot];
                r.status = ST_HIT;
                return r;
            end
            if (shadow_keys[slot] == '0) begin
                if (!realized || fill == '0) begin
                    r.value  = '0;
                    r.status = ST_REFUSED;
                    return r;
                end
                shadow_keys[slot] = key;
                shadow_vals[slot] = fill;
                r.value  = fill;
                r.status = ST_INSERTED;
                return r;
            end
            slot = (slot + 1'b1) & SLOT_MASK;
        end
        r.value  = fill;
        r.status = ST_FULL;
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // all-ones, one-hot, one-cold, alternating and half patterns
    function automatic word_t pattern_word();
        word_t one_hot;
        one_hot = word_t'(1) << $urandom_range(0, WORD_W-1);
        case ($urandom_range(0, 5))
            0: return ALL_ONES;
            1: return one_hot;
            2: return ~one_hot;
            3: return ALT_5;
            4: return ALT_A;
            default: return HI_HALF;
        endcase
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch on result beat %0d: got %h, expected %h",
                     $realtime, what, rx_beats, got, want);
    endtask

    // drive one lookup beat, predict it at acceptance, then maybe idle
    task automatic issue_lookup(input word_t key, input logic realized, input word_t fill,
                                input logic typed, input lookup_t typed_result);
        lookup_t predicted;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {fill, key};
        s_tuser  <= realized;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = cache_lookup(key, realized, fill);
        if (predicted.status == ST_INSERTED)
            known_keys.push_back(key);
        pending_results.push_back(typed ? typed_result : predicted);
        gap = (fast_mode || send_calm > 0) ? 0 : next_gap();
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 29) == 0)
            send_calm = $urandom_range(20, 60);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // mix of repeat lookups, fresh inserts, refusals, zero key and bit patterns
    task automatic random_lookup();
        word_t key;
        word_t fill;
        logic  realized;
        int    roll;
        roll     = $urandom_range(0, 99);
        key      = {$urandom(), $urandom()};
        fill     = {$urandom(), $urandom()};
        realized = 1'b1;
        if (roll < 35 && known_keys.size() > 0) begin
            key      = known_keys[$urandom_range(0, known_keys.size() - 1)];
            realized = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                fill = '0;
        end else if (roll < 70) begin
            fill = fill | word_t'(1 << $urandom_range(0, 31));
        end else if (roll < 80) begin
            realized = 1'b0;
        end else if (roll < 88) begin
            fill = '0;
        end else if (roll < 92) begin
            key      = '0;
            realized = 1'($urandom_range(0, 1));
        end else begin
            key      = pattern_word();
            fill     = pattern_word();
            realized = 1'($urandom_range(0, 1));
        end
        issue_lookup(key, realized, fill, 1'b0, '0);
    endtask

    // source side: reset, directed table, random part, then a closing burst
    initial begin : lookup_source
        lookup_t     want;
        int unsigned fresh;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        aresetn   <= 1'b0;
        fast_mode  = 1'b0;
        send_calm  = 0;
        mismatches = 0;
        rx_beats   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            want.value  = DIRECTED_ROWS[i].want_value;
            want.status = DIRECTED_ROWS[i].want_status;
            issue_lookup(DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].realized,
                         DIRECTED_ROWS[i].fill, DIRECTED_ROWS[i].typed, want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
            random_lookup();

        // back to back: fresh key, zero fill, not realized, zero key, a stored key
        fast_mode = 1'b1;
        fresh     = 32'h1000_0000;
        issue_lookup({fresh, $urandom()}, 1'b1, {$urandom(), $urandom()}, 1'b0, '0);
        fresh++;
        issue_lookup({fresh, $urandom()}, 1'b1, '0, 1'b0, '0);
        fresh++;
        issue_lookup({fresh, $urandom()}, 1'b0, ALL_ONES, 1'b0, '0);
        issue_lookup('0, 1'b1, pattern_word(), 1'b0, '0);
        issue_lookup(known_keys[0], 1'b0, '0, 1'b0, '0);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side: check each beat against the oldest expectation, stall at random
    initial begin : result_sink
        lookup_t want;
        int      stall_left;
        int      calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("value", m_tdata, want.value);
                    if (m_tuser !== want.status)
                        report_mismatch("status", word_t'(m_tuser), word_t'(want.status));
                end
                rx_beats++;
                // long hold-off so the block backs up and stalls its input
                if (rx_beats == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (fast_mode && stall_left == 0) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_tready <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) < 20)
                    stall_left = next_gap();
                else if ($urandom_range(0, 49) == 0)
                    calm_left = $urandom_range(30, 120);
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid & s_tready) === 1'b1 || (m_tvalid & m_tready) === 1'b1)
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("no beat accepted for %0d cycles", idle);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
